FILE: rtl/rmst_pkg.sv
`timescale 1ns / 1ps
package rmst_pkg;

	localparam int MAX_LEAVES = 1024;
	localparam int VALUE_BITS = 32;
	localparam int LEAF_BITS  = $clog2(MAX_LEAVES);
	localparam int NODE_BITS  = LEAF_BITS + 1;
	localparam int CNT_BITS   = LEAF_BITS + 1;
	localparam int SPAN_BITS  = NODE_BITS + 1;
	localparam int NODE_COUNT = 2 * MAX_LEAVES;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [NODE_BITS-1:0]         node_t;
	typedef logic [CNT_BITS-1:0]          count_t;
	typedef logic [LEAF_BITS-1:0]         leaf_t;
	typedef logic [SPAN_BITS-1:0]         span_t;

	localparam value_t VALUE_MAX   = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam count_t LEAF_RESET  = count_t'(MAX_LEAVES);

	typedef enum logic [1:0] {
		MODE_LOAD,
		MODE_BUILD,
		MODE_MODIFY,
		MODE_QUERY
	} mode_t;

	typedef enum logic [3:0] {
		U_IDLE,
		U_LOAD,
		U_BINIT,
		U_BREAD,
		U_BWRITE,
		U_MINIT,
		U_MREAD,
		U_MWRITE,
		U_QINIT,
		U_QREAD,
		U_QACC,
		U_QOUT
	} upc_t;

	typedef enum logic [1:0] {
		W_NONE,
		W_LEAF,
		W_BUILD,
		W_MOD
	} wsel_t;

	typedef enum logic [1:0] {
		R_NONE,
		R_K,
		R_P,
		R_LR
	} rsel_t;

	typedef enum logic [2:0] {
		X_NONE,
		X_KINIT,
		X_KDEC,
		X_PINIT,
		X_PSHIFT,
		X_QINIT,
		X_QSTEP
	} xop_t;

	typedef enum logic [1:0] {
		A_HOLD,
		A_CLEAR,
		A_FOLD
	} aop_t;

	typedef enum logic [3:0] {
		C_ALWAYS,
		C_DISPATCH,
		C_N_ONE,
		C_K_ONE,
		C_M_SKIP,
		C_P_TOP,
		C_Q_EMPTY,
		C_L_LT_R,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		wsel_t wsel;
		rsel_t rsel;
		xop_t  xop;
		aop_t  aop;
		logic  out_ld;
		cond_t cond;
		upc_t  jt;
		upc_t  jf;
	} uword_t;

	function automatic value_t smin(input value_t a, input value_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic upc_t dispatch(input logic [1:0] mode);
		upc_t target;
		unique case (mode_t'(mode))
			MODE_LOAD:   target = U_LOAD;
			MODE_BUILD:  target = U_BINIT;
			MODE_MODIFY: target = U_MINIT;
			MODE_QUERY:  target = U_QINIT;
			default:     target = U_IDLE;
		endcase
		return target;
	endfunction

	// The control store. A step jumps to jt when its condition holds, else to jf.
	function automatic uword_t ucode(input upc_t upc);
		uword_t w;
		unique case (upc)
			U_IDLE:   w = '{W_NONE,  R_NONE, X_NONE,   A_HOLD,  1'b0, C_DISPATCH, U_IDLE,  U_IDLE};
			U_LOAD:   w = '{W_LEAF,  R_NONE, X_NONE,   A_HOLD,  1'b0, C_ALWAYS,   U_IDLE,  U_IDLE};
			U_BINIT:  w = '{W_NONE,  R_NONE, X_KINIT,  A_HOLD,  1'b0, C_N_ONE,    U_IDLE,  U_BREAD};
			U_BREAD:  w = '{W_NONE,  R_K,    X_NONE,   A_HOLD,  1'b0, C_ALWAYS,   U_BWRITE, U_BWRITE};
			U_BWRITE: w = '{W_BUILD, R_NONE, X_KDEC,   A_HOLD,  1'b0, C_K_ONE,    U_IDLE,  U_BREAD};
			U_MINIT:  w = '{W_LEAF,  R_NONE, X_PINIT,  A_HOLD,  1'b0, C_M_SKIP,   U_IDLE,  U_MREAD};
			U_MREAD:  w = '{W_NONE,  R_P,    X_NONE,   A_HOLD,  1'b0, C_ALWAYS,   U_MWRITE, U_MWRITE};
			U_MWRITE: w = '{W_MOD,   R_NONE, X_PSHIFT, A_HOLD,  1'b0, C_P_TOP,    U_IDLE,  U_MREAD};
			U_QINIT:  w = '{W_NONE,  R_NONE, X_QINIT,  A_CLEAR, 1'b0, C_Q_EMPTY,  U_QOUT,  U_QREAD};
			U_QREAD:  w = '{W_NONE,  R_LR,   X_QSTEP,  A_HOLD,  1'b0, C_ALWAYS,   U_QACC,  U_QACC};
			U_QACC:   w = '{W_NONE,  R_NONE, X_NONE,   A_FOLD,  1'b0, C_L_LT_R,   U_QREAD, U_QOUT};
			U_QOUT:   w = '{W_NONE,  R_NONE, X_NONE,   A_HOLD,  1'b1, C_OUT_FREE, U_IDLE,  U_QOUT};
			default:  w = '{W_NONE,  R_NONE, X_NONE,   A_HOLD,  1'b0, C_ALWAYS,   U_IDLE,  U_IDLE};
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/rmst_if.sv
`timescale 1ns / 1ps
interface rmst_req_if;
	import rmst_pkg::*;

	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	leaf_t       position;
	count_t      range_end;
	value_t      value;

	modport source(output valid, output mode, output position, output range_end,
		output value, input ready);
	modport sink(input valid, input mode, input position, input range_end,
		input value, output ready);
endinterface

interface rmst_rsp_if;
	import rmst_pkg::*;

	logic   valid;
	logic   ready;
	value_t minimum;
	logic   empty_range;

	modport source(output valid, output minimum, output empty_range, input ready);
	modport sink(input valid, input minimum, input empty_range, output ready);
endinterface

FILE: rtl/range_minimum_segment_tree.sv
`timescale 1ns / 1ps
// Range minimum segment tree over 1024 signed 32-bit leaves, held in one node memory.
// Requests arrive on req (mode, position, range_end, value); query answers leave on rsp
// (minimum, empty_range). The leaf count register is written through cfg_we/cfg_wdata;
// the user must write it only while the block is idle; the block itself does not enforce
// it. 0 acts as 1 and values above 1024 act as 1024. Load writes one leaf. Build
// fills internal nodes n-1 down to 1 for n leaves. Modify writes the leaf, then
// rewrites each parent up to the root. A query folds the boundary nodes level by level.
// Every tree level is split into steps because the node memory has registered read data:
// one step issues the reads, the next combines them. A new request is taken only when
// the sequencer is back at its idle step. The answer sits in an output register, so a
// stalled receiver does not block the next request; a second answer waits in the
// sequencer until the register frees up. Reset returns the sequencer to idle, empties
// the output register and sets the leaf count to 1024. Node contents are not cleared
// and must be written by load or modify before they are read.
module range_minimum_segment_tree (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  rmst_pkg::count_t  cfg_wdata,
	rmst_req_if.sink          req,
	rmst_rsp_if.source        rsp
);
	import rmst_pkg::*;

	upc_t   upc_q, upc_d;
	uword_t uw;
	logic   cond;
	logic   req_fire;

	count_t leaf_count_q;
	count_t n_c;

	leaf_t  pos_q;
	count_t end_q;
	value_t val_q;

	leaf_t  k_q;
	node_t  p_q;
	span_t  l_q, r_q, r_m1;
	logic   lodd_q, rodd_q, empty_q;
	value_t acc_q;

	value_t tree_mem [NODE_COUNT];
	value_t rd_a_q, rd_b_q;
	node_t  raddr_a, raddr_b, waddr;
	value_t wdata;
	logic   mem_we;

	logic   out_valid_q;
	value_t min_q;
	logic   empty_out_q;
	logic   out_free;

	logic   leaf_ok;
	node_t  leaf_node;
	count_t end_c;
	logic   empty_c;
	value_t pair_min, fold_a, fold_b;

	always_comb begin
		if (leaf_count_q == '0) begin
			n_c = count_t'(1);
		end else if (leaf_count_q > LEAF_RESET) begin
			n_c = LEAF_RESET;
		end else begin
			n_c = leaf_count_q;
		end
	end

	assign leaf_ok   = count_t'(pos_q) < n_c;
	assign leaf_node = node_t'(count_t'(pos_q) + n_c);
	assign end_c     = (end_q > n_c) ? n_c : end_q;
	assign empty_c   = count_t'(pos_q) >= end_c;
	assign r_m1      = r_q - span_t'(1);
	assign pair_min  = smin(rd_a_q, rd_b_q);
	assign fold_a    = lodd_q ? rd_a_q : VALUE_MAX;
	assign fold_b    = rodd_q ? rd_b_q : VALUE_MAX;
	assign out_free  = !out_valid_q || rsp.ready;

	assign req.ready = (upc_q == U_IDLE);
	assign req_fire  = req.valid && req.ready;

	assign uw = ucode(upc_q);

	always_comb begin
		case (uw.cond)
			C_ALWAYS:   cond = 1'b1;
			C_DISPATCH: cond = req_fire;
			C_N_ONE:    cond = n_c == count_t'(1);
			C_K_ONE:    cond = k_q == leaf_t'(1);
			C_M_SKIP:   cond = !leaf_ok || leaf_node == node_t'(1);
			C_P_TOP:    cond = p_q < node_t'(4);
			C_Q_EMPTY:  cond = empty_c;
			C_L_LT_R:   cond = l_q < r_q;
			C_OUT_FREE: cond = out_free;
			default:    cond = 1'b1;
		endcase
	end

	always_comb begin
		if (uw.cond == C_DISPATCH) begin
			upc_d = req_fire ? dispatch(req.mode) : U_IDLE;
		end else begin
			upc_d = cond ? uw.jt : uw.jf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q        <= U_IDLE;
			leaf_count_q <= LEAF_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			upc_q <= upc_d;
			if (cfg_we) begin
				leaf_count_q <= cfg_wdata;
			end
			if (uw.out_ld && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			pos_q <= req.position;
			end_q <= req.range_end;
			val_q <= req.value;
		end
		case (uw.xop)
			X_KINIT:  k_q <= leaf_t'(n_c - count_t'(1));
			X_KDEC:   k_q <= k_q - leaf_t'(1);
			X_PINIT:  p_q <= leaf_node;
			X_PSHIFT: p_q <= p_q >> 1;
			X_QINIT: begin
				l_q     <= span_t'(pos_q) + span_t'(n_c);
				r_q     <= span_t'(end_c) + span_t'(n_c);
				empty_q <= empty_c;
			end
			X_QSTEP: begin
				lodd_q <= l_q[0];
				rodd_q <= r_q[0];
				l_q    <= (l_q + span_t'(1)) >> 1;
				r_q    <= r_q >> 1;
			end
			default: ;
		endcase
		case (uw.aop)
			A_CLEAR: acc_q <= VALUE_MAX;
			A_FOLD:  acc_q <= smin(acc_q, smin(fold_a, fold_b));
			default: ;
		endcase
		if (uw.out_ld && out_free) begin
			min_q       <= acc_q;
			empty_out_q <= empty_q;
		end
	end

	always_comb begin
		case (uw.rsel)
			R_K: begin
				raddr_a = {k_q, 1'b0};
				raddr_b = {k_q, 1'b1};
			end
			R_P: begin
				raddr_a = p_q;
				raddr_b = p_q ^ node_t'(1);
			end
			R_LR: begin
				raddr_a = l_q[NODE_BITS-1:0];
				raddr_b = r_m1[NODE_BITS-1:0];
			end
			default: begin
				raddr_a = '0;
				raddr_b = '0;
			end
		endcase
	end

	always_comb begin
		case (uw.wsel)
			W_LEAF: begin
				mem_we = leaf_ok;
				waddr  = leaf_node;
				wdata  = val_q;
			end
			W_BUILD: begin
				mem_we = 1'b1;
				waddr  = node_t'(k_q);
				wdata  = pair_min;
			end
			W_MOD: begin
				mem_we = 1'b1;
				waddr  = p_q >> 1;
				wdata  = pair_min;
			end
			default: begin
				mem_we = 1'b0;
				waddr  = '0;
				wdata  = val_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tree_mem[waddr] <= wdata;
		end
		rd_a_q <= tree_mem[raddr_a];
		rd_b_q <= tree_mem[raddr_b];
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.minimum     = min_q;
	assign rsp.empty_range = empty_out_q;

	a_empty_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.empty_range |-> rsp.minimum == VALUE_MAX)
		else $error("empty query answered with a value other than the maximum");

	a_query_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == U_QACC |-> l_q <= r_q)
		else $error("query bounds crossed");

	a_build_index: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == U_BREAD |-> k_q != '0)
		else $error("build step reached node zero");

	a_modify_index: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == U_MREAD |-> p_q >= node_t'(2))
		else $error("modify walk passed the root");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while the previous one is in progress");

endmodule
